/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define CHT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache_hit_tracker: assertion failed");

// Next-cycle implication
`define CHT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache_hit_tracker: assertion failed");

`endif

/* src/cht_pkg.sv */
// ---------------------------------------------------------------------------
// cht_pkg
// Constants, register map and shared types of the cache hit tracker.
// ---------------------------------------------------------------------------
package cht_pkg;

    // Geometry defaults
    localparam int LINE_BYTES_DEF = 64;
    localparam int MAX_LINES_DEF  = 64;

    // Address bits that take part in the lookup
    localparam int ADDR_BITS = 32;
    localparam int ADDR_USE  = (ADDR_BITS < 32) ? ADDR_BITS : 32;

    // Size register limits and reset value
    localparam logic [3:0] SIZE_LOG2_MIN   = 4'd7;
    localparam logic [3:0] SIZE_LOG2_MAX   = 4'd12;
    localparam logic [3:0] SIZE_LOG2_RESET = 4'd12;

    // APB address width: three 32-bit registers at 0, 4, 8
    localparam int REG_AW = 4;

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_SIZE_LOG2   = 2'd0,
        REG_FULLY_ASSOC = 2'd1,
        REG_SPLIT_MODE  = 2'd2
    } reg_idx_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [3:0] size_log2;
        logic       fully_assoc;
        logic       split_mode;
    } cht_cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // load the beat and its match vector
        logic commit;   // resolve hit, fill on miss, update counts
    } cht_cmd_t;

endpackage

/* src/cht_in_if.sv */
// ---------------------------------------------------------------------------
// cht_in_if
// Access channel: one address beat with its type.
// ---------------------------------------------------------------------------
interface cht_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        is_data;

    modport source (output valid, output address, output is_data, input ready);
    modport sink   (input valid, input address, input is_data, output ready);
endinterface

/* src/cht_out_if.sv */
// ---------------------------------------------------------------------------
// cht_out_if
// Result channel: hit flag and running counts.
// ---------------------------------------------------------------------------
interface cht_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] access_count;
    logic [31:0] hit_count;

    modport source (output valid, output hit, output access_count, output hit_count,
                    input ready);
    modport sink   (input valid, input hit, input access_count, input hit_count,
                    output ready);
endinterface

/* src/cht_regs.sv */
// ---------------------------------------------------------------------------
// cht_regs
// APB configuration registers: size_log2, fully_assoc, split_mode.
// ---------------------------------------------------------------------------
module cht_regs
    import cht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [REG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cht_cfg_t          cfg
);

    cht_cfg_t cfg_reg;
    cht_cfg_t cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SIZE_LOG2:   cfg_next.size_log2   = pwdata[3:0];
                REG_FULLY_ASSOC: cfg_next.fully_assoc = pwdata[0];
                REG_SPLIT_MODE:  cfg_next.split_mode  = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_log2   <= SIZE_LOG2_RESET;
            cfg_reg.fully_assoc <= 1'b0;
            cfg_reg.split_mode  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_SIZE_LOG2:   prdata = {28'd0, cfg_reg.size_log2};
            REG_FULLY_ASSOC: prdata = {31'd0, cfg_reg.fully_assoc};
            REG_SPLIT_MODE:  prdata = {31'd0, cfg_reg.split_mode};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

/* src/cht_ctrl.sv */
// ---------------------------------------------------------------------------
// cht_ctrl
// Controller: takes one beat, then commits it once the result slot is free.
// ---------------------------------------------------------------------------
module cht_ctrl
    import cht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output cht_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_ready && in_valid;
    // Commit when the result register is empty or draining this cycle
    assign cmd.commit  = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (cmd.capture) state_next = S_UPDATE;
            S_UPDATE: if (cmd.commit)  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Result valid flag
    always_comb
    begin
        priority if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/cht_datapath.sv */
// ---------------------------------------------------------------------------
// cht_datapath
// Tag store with one comparator per line, FIFO pointers and hit counters.
// ---------------------------------------------------------------------------
module cht_datapath
    import cht_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int MAX_LINES  = MAX_LINES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cht_cfg_t    cfg,
    input  cht_cmd_t    cmd,
    input  logic [31:0] address,
    input  logic        is_data,
    output logic        hit,
    output logic [31:0] access_count,
    output logic [31:0] hit_count
);

    localparam int         OFF_BITS = $clog2(LINE_BYTES);
    localparam int         LINE_W   = $clog2(MAX_LINES);
    localparam int         TAG_W    = ADDR_USE - OFF_BITS;
    localparam logic [4:0] OFF5     = 5'(OFF_BITS);
    localparam logic [4:0] LINE_W5  = 5'(LINE_W);

    // Line store
    logic [TAG_W-1:0]     line_tags_reg [MAX_LINES];
    logic [MAX_LINES-1:0] line_valid_reg;
    logic [LINE_W-1:0]    instr_ptr_reg;
    logic [LINE_W-1:0]    data_ptr_reg;
    logic [31:0]          accesses_reg;
    logic [31:0]          hits_reg;
    logic                 hit_reg;

    // Captured beat
    logic [TAG_W-1:0]     tag_reg;
    logic [LINE_W-1:0]    fill_line_reg;
    logic                 fa_reg;
    logic                 use_dptr_reg;
    logic [LINE_W-1:0]    next_ptr_reg;
    logic [MAX_LINES-1:0] match_reg;

    // Geometry and lookup terms
    logic [3:0]           sl_c;
    logic [4:0]           diff;
    logic [4:0]           lines_log2;
    logic [4:0]           half_log2;
    logic [LINE_W-1:0]    half_mask;
    logic [LINE_W-1:0]    base;
    logic [TAG_W-1:0]     line_addr;
    logic [TAG_W-1:0]     tag_sel;
    logic [LINE_W-1:0]    dm_line;
    logic                 use_dptr;
    logic [LINE_W-1:0]    slot;
    logic [LINE_W-1:0]    fill_line;
    logic [LINE_W-1:0]    fa_next;
    logic [MAX_LINES-1:0] match_next;
    logic                 in_range;
    logic                 hit_now;
    logic [31:0]          accesses_next;
    logic [31:0]          hits_next;

    // Line count, half size and the target line of this beat
    always_comb
    begin
        if (cfg.size_log2 < SIZE_LOG2_MIN)
            sl_c = SIZE_LOG2_MIN;
        else if (cfg.size_log2 > SIZE_LOG2_MAX)
            sl_c = SIZE_LOG2_MAX;
        else
            sl_c = cfg.size_log2;

        if ({1'b0, sl_c} > OFF5)
            diff = {1'b0, sl_c} - OFF5;
        else
            diff = 5'd0;

        // line count held between 2 and MAX_LINES
        if (diff < 5'd1)
            lines_log2 = 5'd1;
        else if (diff > LINE_W5)
            lines_log2 = LINE_W5;
        else
            lines_log2 = diff;

        half_log2 = lines_log2 - {4'd0, cfg.split_mode};
        half_mask = ~({LINE_W{1'b1}} << half_log2);
        use_dptr  = cfg.split_mode && is_data;
        base      = use_dptr ? (LINE_W'(1) << half_log2) : '0;

        line_addr = address[ADDR_USE-1:OFF_BITS];
        dm_line   = base | (line_addr[LINE_W-1:0] & half_mask);

        slot      = (use_dptr ? data_ptr_reg : instr_ptr_reg) & half_mask;
        fa_next   = (slot + LINE_W'(1)) & half_mask;

        if (cfg.fully_assoc)
        begin
            tag_sel   = line_addr;
            fill_line = base | slot;
        end
        else
        begin
            tag_sel   = line_addr >> half_log2;
            fill_line = dm_line;
        end
    end

    // One comparator per line; the range picks the lines this beat may hit
    always_comb
    begin
        for (int i = 0; i < MAX_LINES; i++)
        begin
            if (cfg.fully_assoc)
                in_range = ((LINE_W'(i) & ~half_mask) == base);
            else
                in_range = (LINE_W'(i) == dm_line);
            match_next[i] = line_valid_reg[i] && in_range && (line_tags_reg[i] == tag_sel);
        end
    end

    // Beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_reg       <= tag_sel;
            fill_line_reg <= fill_line;
            fa_reg        <= cfg.fully_assoc;
            use_dptr_reg  <= use_dptr;
            next_ptr_reg  <= fa_next;
            match_reg     <= match_next;
        end
    end

    // Resolve and saturating counts
    assign hit_now       = |match_reg;
    assign accesses_next = (accesses_reg != 32'hFFFF_FFFF) ? accesses_reg + 32'd1
                                                           : accesses_reg;
    assign hits_next     = (hit_now && (hits_reg != 32'hFFFF_FFFF)) ? hits_reg + 32'd1
                                                                    : hits_reg;

    // Tag fill on miss
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_now)
            line_tags_reg[fill_line_reg] <= tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
            instr_ptr_reg  <= '0;
            data_ptr_reg   <= '0;
            accesses_reg   <= '0;
            hits_reg       <= '0;
            hit_reg        <= 1'b0;
        end
        else if (cmd.commit)
        begin
            accesses_reg <= accesses_next;
            hits_reg     <= hits_next;
            hit_reg      <= hit_now;
            if (!hit_now)
            begin
                line_valid_reg[fill_line_reg] <= 1'b1;
                if (fa_reg && use_dptr_reg)
                    data_ptr_reg <= next_ptr_reg;
                else if (fa_reg)
                    instr_ptr_reg <= next_ptr_reg;
            end
        end
    end

    // Counts only move at commit, so they double as the result payload
    assign hit          = hit_reg;
    assign access_count = accesses_reg;
    assign hit_count    = hits_reg;

endmodule

/* src/cache_hit_tracker.sv */
// Sequencing: an accepted beat is captured, then committed once the result
// register is free; the result is registered at commit.
// No new beat is taken until the previous one commits (compare, then fill on the tag store).
// A pending result does not block the next beat from being taken.
// Reset (rst_n, async, active low): valid bits, FIFO pointers and counts cleared,
// registers back to size_log2 = 12, direct-mapped, unified; ready right after reset.
// ---------------------------------------------------------------------------
// cache_hit_tracker
// Cache tag store model with hit and access counts, APB configured.
// ---------------------------------------------------------------------------
module cache_hit_tracker
    import cht_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int MAX_LINES  = MAX_LINES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    cht_in_if.sink            in_ch,
    cht_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [REG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cht_cfg_t cfg;
    cht_cmd_t cmd;

    // Configuration registers
    cht_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencing
    cht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // Tag store and counters
    cht_datapath #(
        .LINE_BYTES (LINE_BYTES),
        .MAX_LINES  (MAX_LINES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .address      (in_ch.address),
        .is_data      (in_ch.is_data),
        .hit          (out_ch.hit),
        .access_count (out_ch.access_count),
        .hit_count    (out_ch.hit_count)
    );

endmodule

/* src/cht_checker.sv */
// ---------------------------------------------------------------------------
// cht_checker
// Port-level checks on the cache hit tracker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic [31:0] access_count,
    input logic [31:0] hit_count
);

    // Hits can never outrun accesses
    `CHT_ASSERT_IMP(a_hits_le_accesses, out_valid, hit_count <= access_count)

    // A reported hit has been counted
    `CHT_ASSERT_IMP(a_hit_counted, out_valid && hit, hit_count != 32'd0)

    // Only one beat in flight: ready drops after a beat is taken
    `CHT_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // A stalled result beat holds
    `CHT_ASSERT_NXT(a_stall_holds, out_valid && !out_ready,
                    out_valid && $stable(hit) && $stable(access_count) && $stable(hit_count))

endmodule

bind cache_hit_tracker cht_checker u_cht_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .hit          (out_ch.hit),
    .access_count (out_ch.access_count),
    .hit_count    (out_ch.hit_count)
);

/* verif/tb_cache_hit_tracker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cache_hit_tracker
// Checks the cache hit tracker against a cycle-free model of its tag store.
// Lookups run through a series of cache geometries set over APB. Each result
// beat is compared field by field with the hit flag and running counts that
// the model works out for the accepted access.
// ---------------------------------------------------------------------------
module tb_cache_hit_tracker;
    import cht_pkg::*;

    // One access as offered on the input channel
    typedef struct {
        logic [31:0] address;
        logic        is_data;
    } lookup_t;

    // One result as it should leave the block
    typedef struct {
        logic        hit;
        logic [31:0] access_count;
        logic [31:0] hit_count;
    } outcome_t;

    // Geometry plan after the directed part: size, mapping, split
    localparam int PLAN_LEN = 8;
    localparam logic [3:0] PLAN_SIZE [PLAN_LEN] = '{4'd12, 4'd7, 4'd7, 4'd12,
                                                    4'd9, 4'd15, 4'd3, 4'd10};
    localparam logic PLAN_ASSOC [PLAN_LEN] = '{1'b1, 1'b0, 1'b1, 1'b1,
                                               1'b0, 1'b1, 1'b0, 1'b1};
    localparam logic PLAN_SPLIT [PLAN_LEN] = '{1'b0, 1'b1, 1'b1, 1'b1,
                                               1'b0, 1'b0, 1'b1, 1'b1};
    localparam int PHASE_LOOKUPS = 160;
    localparam int HOT_DEPTH     = 96;
    localparam int HOLD_AT       = 450;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_FROM    = 700;
    localparam int QUIET_TO      = 900;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [REG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    cht_in_if  in_ch ();
    cht_out_if out_ch ();

    cache_hit_tracker i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model copy of configuration and tag store
    logic [3:0]  cfg_size;
    logic        cfg_assoc;
    logic        cfg_split;
    logic [25:0] model_tags [64];
    logic        model_valid [64];
    int unsigned instr_next;
    int unsigned data_next;
    logic [31:0] model_accesses;
    logic [31:0] model_hits;

    lookup_t     pending_lookups[$];
    outcome_t    predicted_outcomes[$];
    logic [31:0] hot_lines [HOT_DEPTH];

    int unsigned lookups_sent;
    int unsigned results_taken;
    int unsigned hold_left;
    int unsigned mismatches;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Look up one access in the model, fill on miss, queue its outcome
    function automatic void track_access(input logic [31:0] addr, input logic is_data);
        int unsigned sl;
        int unsigned lines;
        int unsigned half;
        int unsigned base;
        int unsigned idx_bits;
        int unsigned slot;
        int unsigned ln;
        int unsigned i;
        logic [25:0] tag;
        logic        hit;
        outcome_t    res;
        hit = 1'b0;
        sl  = 32'(cfg_size);
        if (sl < 7)
            sl = 7;
        if (sl > 12)
            sl = 12;
        lines = (1 << sl) >> 6;
        if (lines < 2)
            lines = 2;
        if (lines > 64)
            lines = 64;
        half = cfg_split ? lines / 2 : lines;
        base = (cfg_split && is_data) ? half : 0;
        if (cfg_assoc)
        begin
            tag = addr[31:6];
            for (i = 0; i < half; i++)
                if (model_valid[base + i] && model_tags[base + i] == tag)
                    hit = 1'b1;
            if (!hit)
            begin
                // FIFO victim; the pointer may lie beyond a shrunk half
                if (cfg_split && is_data)
                begin
                    slot      = data_next % half;
                    data_next = (slot + 1) % half;
                end
                else
                begin
                    slot       = instr_next % half;
                    instr_next = (slot + 1) % half;
                end
                ln              = base + slot;
                model_tags[ln]  = tag;
                model_valid[ln] = 1'b1;
            end
        end
        else
        begin
            idx_bits = $clog2(half);
            ln       = base + ((addr >> 6) & (half - 1));
            tag      = 26'(addr >> (6 + idx_bits));
            if (model_valid[ln] && model_tags[ln] == tag)
                hit = 1'b1;
            else
            begin
                model_tags[ln]  = tag;
                model_valid[ln] = 1'b1;
            end
        end
        // Saturating counts
        if (model_accesses != 32'hFFFF_FFFF)
            model_accesses = model_accesses + 1;
        if (hit && model_hits != 32'hFFFF_FFFF)
            model_hits = model_hits + 1;
        res.hit          = hit;
        res.access_count = model_accesses;
        res.hit_count    = model_hits;
        predicted_outcomes.push_back(res);
    endfunction

    // Mix of reused lines, index/tag conflicts and wild addresses
    function automatic logic [31:0] pick_address(input int unsigned hot_n);
        int unsigned roll;
        logic [31:0] a;
        roll = $urandom_range(0, 99);
        a    = hot_lines[$urandom_range(0, hot_n - 1)];
        if (roll < 15)
            a = $urandom();
        else if (roll < 45)
            a = a ^ (32'h1 << $urandom_range(6, 31));
        else
            a[5:0] = 6'($urandom_range(0, 63));
        return a;
    endfunction

    function automatic void queue_access(input logic [31:0] addr, input logic is_data);
        lookup_t lk;
        lk.address = addr;
        lk.is_data = is_data;
        pending_lookups.push_back(lk);
    endfunction

    // APB write: setup then access, done once pready is seen
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIZE_LOG2:   cfg_size  = val[3:0];
            REG_FULLY_ASSOC: cfg_assoc = val[0];
            REG_SPLIT_MODE:  cfg_split = val[0];
            default:         ;
        endcase
    endtask

    task automatic set_geometry(input logic [3:0] sz, input logic assoc, input logic split);
        reg_write(REG_SIZE_LOG2, {28'd0, sz});
        reg_write(REG_FULLY_ASSOC, {31'd0, assoc});
        reg_write(REG_SPLIT_MODE, {31'd0, split});
    endtask

    // Hold the sender until every outcome is back and the block is quiet
    task automatic settle();
        do
            @(negedge clk);
        while (pending_lookups.size() != 0 || in_ch.valid || predicted_outcomes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Driver: offer the next lookup, predict on each accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                track_access(in_ch.address, in_ch.is_data);
                lookups_sent <= lookups_sent + 1;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_lookups.size() != 0 &&
                    ((lookups_sent >= QUIET_FROM && lookups_sent < QUIET_TO) ||
                     $urandom_range(0, 99) >= 10))
                begin
                    in_ch.valid   <= 1'b1;
                    in_ch.address <= pending_lookups[0].address;
                    in_ch.is_data <= pending_lookups[0].is_data;
                    void'(pending_lookups.pop_front());
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_taken <= results_taken + 1;
                if (predicted_outcomes.size() == 0)
                begin
                    $error("result beat with no access outstanding");
                    mismatches++;
                end
                else
                begin
                    if (out_ch.hit !== predicted_outcomes[0].hit)
                    begin
                        $error("hit: expected %0b, got %0b",
                               predicted_outcomes[0].hit, out_ch.hit);
                        mismatches++;
                    end
                    if (out_ch.access_count !== predicted_outcomes[0].access_count)
                    begin
                        $error("access_count: expected %0d, got %0d",
                               predicted_outcomes[0].access_count, out_ch.access_count);
                        mismatches++;
                    end
                    if (out_ch.hit_count !== predicted_outcomes[0].hit_count)
                    begin
                        $error("hit_count: expected %0d, got %0d",
                               predicted_outcomes[0].hit_count, out_ch.hit_count);
                        mismatches++;
                    end
                    void'(predicted_outcomes.pop_front());
                end
            end
            out_ch.ready <= (hold_left == 0) &&
                            ((results_taken >= QUIET_FROM && results_taken < QUIET_TO) ||
                             $urandom_range(0, 99) >= 10);
        end
    end

    // Long receiver hold-off once, so the block backs up into its input
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (out_ch.valid && out_ch.ready && results_taken == HOLD_AT)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Stimulus
    initial
    begin
        int unsigned hot_n;
        int unsigned p;
        int unsigned k;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.address = 32'd0;
        in_ch.is_data = 1'b0;
        out_ch.ready  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = 32'd0;
        cfg_size      = SIZE_LOG2_RESET;
        cfg_assoc     = 1'b0;
        cfg_split     = 1'b0;
        foreach (model_valid[i])
            model_valid[i] = 1'b0;
        instr_next     = 0;
        data_next      = 0;
        model_accesses = 32'd0;
        model_hits     = 32'd0;
        lookups_sent   = 0;
        results_taken  = 0;
        mismatches     = 0;
        foreach (hot_lines[i])
            hot_lines[i] = $urandom();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry, direct-mapped unified: address extremes, same line,
        // index conflict with eviction, last set
        queue_access(32'h0000_0000, 1'b0);
        queue_access(32'h0000_003F, 1'b1);
        queue_access(32'hFFFF_FFFF, 1'b1);
        queue_access(32'hFFFF_FFC0, 1'b0);
        queue_access(32'h0000_1000, 1'b0);
        queue_access(32'h0000_0000, 1'b1);
        queue_access(32'h0000_0FC0, 1'b0);
        queue_access(32'h0000_0FFF, 1'b1);
        settle();

        // Smallest split fully associative: one line per half, FIFO wrap
        set_geometry(4'd7, 1'b1, 1'b1);
        queue_access(32'h0000_0100, 1'b0);
        queue_access(32'h0000_013F, 1'b0);
        queue_access(32'h0000_0100, 1'b1);
        queue_access(32'h0000_0200, 1'b0);
        queue_access(32'h0000_0100, 1'b0);
        queue_access(32'h0000_0100, 1'b1);
        queue_access(32'hFFFF_FFC0, 1'b1);
        queue_access(32'hFFFF_FFFF, 1'b1);
        settle();

        // Random phases over the geometry plan, no flush between them
        for (p = 0; p < PLAN_LEN; p++)
        begin
            set_geometry(PLAN_SIZE[p], PLAN_ASSOC[p], PLAN_SPLIT[p]);
            hot_n = $urandom_range(2, HOT_DEPTH);
            for (k = 0; k < PHASE_LOOKUPS; k++)
                queue_access(pick_address(hot_n), 1'($urandom_range(0, 1)));
            settle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && predicted_outcomes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
